FILE: sv/ucdc_pkg.sv
package ucdc_pkg;

    // Default size of the per-interface alternate setting table.
    localparam int MAX_INTERFACES_DEFAULT = 32;

    // Descriptor type codes and length limits.
    localparam logic [7:0] DESC_INTERFACE      = 8'h04;
    localparam logic [7:0] DESC_ENDPOINT       = 8'h05;
    localparam logic [7:0] MIN_LENGTH          = 8'd2;
    localparam logic [7:0] INTERFACE_LENGTH    = 8'd9;
    localparam logic [7:0] ENDPOINT_MIN_LENGTH = 8'd7;
    localparam logic [7:0] ALT_LIMIT           = 8'hFF;

    // Byte positions of interest inside the configuration header.
    localparam logic [7:0] HDR_POS_LENGTH     = 8'd0;
    localparam logic [7:0] HDR_POS_TYPE       = 8'd1;
    localparam logic [7:0] HDR_POS_INTERFACES = 8'd4;
    localparam logic [7:0] HDR_POS_LAST       = 8'd8;

    // Byte positions inside a chained descriptor.
    localparam logic [7:0] POS_LENGTH = 8'd0;
    localparam logic [7:0] POS_TYPE   = 8'd1;
    localparam logic [7:0] POS_FIELD  = 8'd2;
    localparam logic [7:0] POS_ALT    = 8'd3;

    // Record queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_HEADER         = 3'd0,
        KIND_INTERFACE      = 3'd1,
        KIND_ENDPOINT       = 3'd2,
        KIND_EXTRA_ATTACHED = 3'd3,
        KIND_EXTRA_IGNORED  = 3'd4,
        KIND_ERROR          = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_SHORT_HEADER = 3'd1,
        ERR_BAD_LENGTH   = 3'd2,
        ERR_IFACE_SIZE   = 3'd3,
        ERR_NUM_RANGE    = 3'd4,
        ERR_ALT_ORDER    = 3'd5,
        ERR_ENDPOINT     = 3'd6,
        ERR_CAPACITY     = 3'd7
    } err_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_WALK   = 2'd1,
        PH_FAILED = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        err_t       code;
        logic [7:0] dtype;
        logic [7:0] dlen;
        logic [7:0] ifnum;
        logic [7:0] alt;
        logic [7:0] ep;
        logic [7:0] icount;
        logic       stream_end;
    } rec_t;

endpackage

FILE: sv/ucdc_front.sv
module ucdc_front #(
    parameter int MAX_INTERFACES = ucdc_pkg::MAX_INTERFACES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             space,
    output logic             byte_ready,
    output logic             push,
    output ucdc_pkg::rec_t   rec
);

    localparam int IDX_W = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam logic [8:0] MAX_IF = 9'(MAX_INTERFACES);

    ucdc_pkg::phase_t phase_reg, phase_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] decl_reg, decl_next;
    logic       open_reg, open_next;
    logic [7:0] iface_reg, iface_next;
    logic [7:0] alt_reg, alt_next;
    logic [MAX_INTERFACES-1:0] cnt_vld_reg, cnt_vld_next;
    logic       cnt_rd_vld_reg, cnt_rd_vld_next;
    logic [7:0] cnt_rd_reg;
    logic [7:0] cnt_mem [MAX_INTERFACES];

    logic             accept;
    logic             emit;
    logic [7:0]       len_eff;
    logic [7:0]       type_cur;
    logic [7:0]       type_new;
    logic [7:0]       held_new;
    logic [7:0]       alt_cur;
    logic             finished;
    logic             short_fail;
    logic             alt_commit;
    logic             mem_re;
    logic [IDX_W-1:0] idx_in;
    logic [IDX_W-1:0] idx_held;
    ucdc_pkg::err_t   walk_err;

    // A beat is taken whenever the record queue has room.
    assign byte_ready = space;
    assign accept     = byte_valid & space;
    assign push       = accept & emit;

    // Values seen by the current byte of a chained descriptor.
    assign len_eff    = (pos_reg == ucdc_pkg::POS_LENGTH) ? data_byte : len_reg;
    assign type_cur   = (pos_reg == ucdc_pkg::POS_LENGTH) ? 8'd0 : type_reg;
    assign type_new   = (pos_reg == ucdc_pkg::POS_TYPE) ? data_byte : type_cur;
    assign finished   = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_eff};
    assign short_fail = last_byte & ~finished;
    assign alt_cur    = cnt_rd_vld_reg ? cnt_rd_reg : 8'd0;
    assign idx_in     = data_byte[IDX_W-1:0];
    assign idx_held   = held_reg[IDX_W-1:0];

    // The field byte is kept for interfaces and endpoints, and dropped at each new descriptor.
    always_comb
    begin
        held_new = held_reg;
        if (pos_reg == ucdc_pkg::POS_LENGTH)
        begin
            held_new = 8'd0;
        end
        else if (pos_reg == ucdc_pkg::POS_FIELD &&
                 (type_cur == ucdc_pkg::DESC_INTERFACE || type_cur == ucdc_pkg::DESC_ENDPOINT))
        begin
            held_new = data_byte;
        end
    end

    // Checks on one byte of a chained descriptor, in order of precedence.
    always_comb
    begin
        walk_err = ucdc_pkg::ERR_NONE;
        if (pos_reg == ucdc_pkg::POS_LENGTH && data_byte < ucdc_pkg::MIN_LENGTH)
        begin
            walk_err = ucdc_pkg::ERR_BAD_LENGTH;
        end
        else if (short_fail)
        begin
            walk_err = ucdc_pkg::ERR_BAD_LENGTH;
        end
        else if (pos_reg == ucdc_pkg::POS_TYPE)
        begin
            if (data_byte == ucdc_pkg::DESC_INTERFACE && len_reg != ucdc_pkg::INTERFACE_LENGTH)
            begin
                walk_err = ucdc_pkg::ERR_IFACE_SIZE;
            end
            else if (data_byte == ucdc_pkg::DESC_ENDPOINT &&
                     (!open_reg || len_reg < ucdc_pkg::ENDPOINT_MIN_LENGTH))
            begin
                walk_err = ucdc_pkg::ERR_ENDPOINT;
            end
        end
        else if (pos_reg == ucdc_pkg::POS_FIELD && type_cur == ucdc_pkg::DESC_INTERFACE)
        begin
            if (data_byte >= decl_reg)
            begin
                walk_err = ucdc_pkg::ERR_NUM_RANGE;
            end
            else if ({1'b0, data_byte} >= MAX_IF)
            begin
                walk_err = ucdc_pkg::ERR_CAPACITY;
            end
        end
        else if (pos_reg == ucdc_pkg::POS_ALT && type_cur == ucdc_pkg::DESC_INTERFACE)
        begin
            if (alt_cur != data_byte)
            begin
                walk_err = ucdc_pkg::ERR_ALT_ORDER;
            end
            else if (alt_cur == ucdc_pkg::ALT_LIMIT)
            begin
                walk_err = ucdc_pkg::ERR_CAPACITY;
            end
        end
    end

    // An interface opens when its alternate setting byte passes the checks.
    assign alt_commit = (phase_reg == ucdc_pkg::PH_WALK) && (pos_reg == ucdc_pkg::POS_ALT) &&
                        (type_cur == ucdc_pkg::DESC_INTERFACE) &&
                        (walk_err == ucdc_pkg::ERR_NONE);

    // The counter is fetched on the interface number byte, one byte ahead of its use.
    assign mem_re = accept && (phase_reg == ucdc_pkg::PH_WALK) &&
                    (pos_reg == ucdc_pkg::POS_FIELD) && (type_cur == ucdc_pkg::DESC_INTERFACE);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                ucdc_pkg::PH_HEADER:
                begin
                    if (pos_reg >= ucdc_pkg::HDR_POS_LAST)
                    begin
                        phase_next = ucdc_pkg::PH_WALK;
                    end
                end
                ucdc_pkg::PH_WALK:
                begin
                    if (walk_err != ucdc_pkg::ERR_NONE)
                    begin
                        phase_next = ucdc_pkg::PH_FAILED;
                    end
                end
                ucdc_pkg::PH_FAILED:
                begin
                    phase_next = ucdc_pkg::PH_FAILED;
                end
                default:
                begin
                    phase_next = ucdc_pkg::PH_HEADER;
                end
            endcase
            // Every last byte starts a fresh stream.
            if (last_byte)
            begin
                phase_next = ucdc_pkg::PH_HEADER;
            end
        end
    end

    // Record built for the current byte.
    always_comb
    begin
        emit           = 1'b0;
        rec.kind       = ucdc_pkg::KIND_ERROR;
        rec.code       = ucdc_pkg::ERR_NONE;
        rec.dtype      = type_reg;
        rec.dlen       = len_reg;
        rec.ifnum      = 8'd0;
        rec.alt        = 8'd0;
        rec.ep         = 8'd0;
        rec.icount     = decl_reg;
        rec.stream_end = last_byte;
        case (phase_reg)
            ucdc_pkg::PH_HEADER:
            begin
                if (pos_reg >= ucdc_pkg::HDR_POS_LAST)
                begin
                    emit     = 1'b1;
                    rec.kind = ucdc_pkg::KIND_HEADER;
                end
                else if (last_byte)
                begin
                    emit     = 1'b1;
                    rec.code = ucdc_pkg::ERR_SHORT_HEADER;
                    if (pos_reg == ucdc_pkg::HDR_POS_LENGTH)
                    begin
                        rec.dlen = data_byte;
                    end
                    if (pos_reg == ucdc_pkg::HDR_POS_TYPE)
                    begin
                        rec.dtype = data_byte;
                    end
                    if (pos_reg == ucdc_pkg::HDR_POS_INTERFACES)
                    begin
                        rec.icount = data_byte;
                    end
                end
            end
            ucdc_pkg::PH_WALK:
            begin
                rec.dlen = len_eff;
                if (walk_err != ucdc_pkg::ERR_NONE)
                begin
                    emit      = 1'b1;
                    rec.code  = walk_err;
                    rec.dtype = short_fail ? type_cur : type_new;
                    rec.ifnum = open_reg ? iface_reg : 8'd0;
                    rec.alt   = open_reg ? alt_reg : 8'd0;
                end
                else if (finished)
                begin
                    emit      = 1'b1;
                    rec.dtype = type_new;
                    rec.ifnum = open_next ? iface_next : 8'd0;
                    rec.alt   = open_next ? alt_next : 8'd0;
                    if (type_new == ucdc_pkg::DESC_INTERFACE)
                    begin
                        rec.kind = ucdc_pkg::KIND_INTERFACE;
                    end
                    else if (type_new == ucdc_pkg::DESC_ENDPOINT)
                    begin
                        rec.kind = ucdc_pkg::KIND_ENDPOINT;
                        rec.ep   = held_new;
                    end
                    else if (open_next)
                    begin
                        rec.kind = ucdc_pkg::KIND_EXTRA_ATTACHED;
                    end
                    else
                    begin
                        rec.kind = ucdc_pkg::KIND_EXTRA_IGNORED;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Open interface follows a successful alternate setting byte.
    always_comb
    begin
        open_next  = open_reg;
        iface_next = iface_reg;
        alt_next   = alt_reg;
        if (alt_commit)
        begin
            open_next  = 1'b1;
            iface_next = held_reg;
            alt_next   = data_byte;
        end
    end

    // Next values of the stream state.
    always_comb
    begin
        pos_next        = pos_reg;
        len_next        = len_reg;
        type_next       = type_reg;
        held_next       = held_reg;
        decl_next       = decl_reg;
        cnt_vld_next    = cnt_vld_reg;
        cnt_rd_vld_next = cnt_rd_vld_reg;
        if (accept)
        begin
            if (phase_reg == ucdc_pkg::PH_HEADER)
            begin
                if (pos_reg >= ucdc_pkg::HDR_POS_LAST)
                begin
                    pos_next  = 8'd0;
                    len_next  = 8'd0;
                    type_next = 8'd0;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                    if (pos_reg == ucdc_pkg::HDR_POS_LENGTH)
                    begin
                        len_next = data_byte;
                    end
                    if (pos_reg == ucdc_pkg::HDR_POS_TYPE)
                    begin
                        type_next = data_byte;
                    end
                    if (pos_reg == ucdc_pkg::HDR_POS_INTERFACES)
                    begin
                        decl_next = data_byte;
                    end
                end
            end
            else if (phase_reg == ucdc_pkg::PH_WALK && walk_err == ucdc_pkg::ERR_NONE)
            begin
                len_next  = len_eff;
                type_next = type_new;
                held_next = held_new;
                pos_next  = finished ? 8'd0 : pos_reg + 8'd1;
                if (alt_commit)
                begin
                    cnt_vld_next[idx_held] = 1'b1;
                end
            end
            if (mem_re)
            begin
                cnt_rd_vld_next = cnt_vld_reg[idx_in];
            end
            // The last byte returns everything but the counter read state to the start of a stream.
            if (last_byte)
            begin
                pos_next     = 8'd0;
                len_next     = 8'd0;
                type_next    = 8'd0;
                held_next    = 8'd0;
                decl_next    = 8'd0;
                cnt_vld_next = '0;
            end
        end
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ucdc_pkg::PH_HEADER;
            pos_reg        <= 8'd0;
            len_reg        <= 8'd0;
            type_reg       <= 8'd0;
            held_reg       <= 8'd0;
            decl_reg       <= 8'd0;
            open_reg       <= 1'b0;
            iface_reg      <= 8'd0;
            alt_reg        <= 8'd0;
            cnt_vld_reg    <= '0;
            cnt_rd_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            type_reg       <= type_next;
            held_reg       <= held_next;
            decl_reg       <= decl_next;
            cnt_vld_reg    <= cnt_vld_next;
            cnt_rd_vld_reg <= cnt_rd_vld_next;
            if (accept && last_byte)
            begin
                open_reg  <= 1'b0;
                iface_reg <= 8'd0;
                alt_reg   <= 8'd0;
            end
            else if (accept)
            begin
                open_reg  <= open_next;
                iface_reg <= iface_next;
                alt_reg   <= alt_next;
            end
        end
    end

    // Alternate setting counters; an entry whose valid bit is clear reads as zero.
    always_ff @(posedge clk)
    begin
        if (accept && alt_commit)
        begin
            cnt_mem[idx_held] <= data_byte + 8'd1;
        end
        if (mem_re)
        begin
            cnt_rd_reg <= cnt_mem[idx_in];
        end
    end

endmodule

FILE: sv/ucdc_queue.sv
module ucdc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ucdc_pkg::rec_t rec_in,
    input  logic           pop,
    output logic           space,
    output logic           nonempty,
    output ucdc_pkg::rec_t rec_out
);

    localparam logic [ucdc_pkg::QPTR_W-1:0] PTR_LAST = ucdc_pkg::QPTR_W'(ucdc_pkg::QUEUE_DEPTH - 1);
    localparam logic [ucdc_pkg::QCNT_W-1:0] CNT_FULL = ucdc_pkg::QCNT_W'(ucdc_pkg::QUEUE_DEPTH);

    ucdc_pkg::rec_t slot_reg [ucdc_pkg::QUEUE_DEPTH];
    logic [ucdc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ucdc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ucdc_pkg::QCNT_W-1:0] count_reg, count_next;

    assign space    = (count_reg != CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign rec_out  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= rec_in;
        end
    end

endmodule

FILE: sv/ucdc_back.sv
module ucdc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           nonempty,
    input  ucdc_pkg::rec_t rec_in,
    input  logic           record_ready,
    output logic           pop,
    output logic           record_valid,
    output ucdc_pkg::rec_t rec_out
);

    logic           out_valid_reg, out_valid_next;
    ucdc_pkg::rec_t out_rec_reg;

    // Load the next record when the output register is empty or being drained.
    assign pop            = nonempty & (~out_valid_reg | record_ready);
    assign out_valid_next = pop | (out_valid_reg & ~record_ready);
    assign record_valid   = out_valid_reg;
    assign rec_out        = out_rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_rec_reg <= rec_in;
        end
    end

endmodule

FILE: sv/usb_config_descriptor_checker.sv
// A record for an accepted byte passes through the record queue and then the output register
// before it is offered on the outputs.
// Throughput: one byte per cycle; a two-entry record queue and the output register
// let the parser run on while the output stalls, and byte_ready falls when both are full.
// Reset: rst_n is asynchronous and clears the parser state, the counter valid bits and the queue.
module usb_config_descriptor_checker #(
    parameter int MAX_INTERFACES = ucdc_pkg::MAX_INTERFACES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       record_valid,
    input  logic       record_ready,
    output logic [2:0] record_kind,
    output logic [2:0] error_code,
    output logic [7:0] descriptor_type,
    output logic [7:0] descriptor_length,
    output logic [7:0] interface_number,
    output logic [7:0] alternate_setting,
    output logic [7:0] endpoint_address,
    output logic [7:0] interface_count,
    output logic       stream_end
);

    logic           space;
    logic           push;
    logic           pop;
    logic           nonempty;
    ucdc_pkg::rec_t front_rec;
    ucdc_pkg::rec_t queue_rec;
    ucdc_pkg::rec_t out_rec;

    // Parser: takes one beat per cycle while the record queue has room, and classifies it.
    ucdc_front #(
        .MAX_INTERFACES(MAX_INTERFACES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .space      (space),
        .byte_ready (byte_ready),
        .push       (push),
        .rec        (front_rec)
    );

    // Record queue decoupling the parser from the output.
    ucdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rec_in   (front_rec),
        .pop      (pop),
        .space    (space),
        .nonempty (nonempty),
        .rec_out  (queue_rec)
    );

    // Output register.
    ucdc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nonempty     (nonempty),
        .rec_in       (queue_rec),
        .record_ready (record_ready),
        .pop          (pop),
        .record_valid (record_valid),
        .rec_out      (out_rec)
    );

    assign record_kind       = out_rec.kind;
    assign error_code        = out_rec.code;
    assign descriptor_type   = out_rec.dtype;
    assign descriptor_length = out_rec.dlen;
    assign interface_number  = out_rec.ifnum;
    assign alternate_setting = out_rec.alt;
    assign endpoint_address  = out_rec.ep;
    assign interface_count   = out_rec.icount;
    assign stream_end        = out_rec.stream_end;

`ifndef ASSERT_OFF
    // Input back-pressure only ever comes from a record waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n) !byte_ready |-> record_valid)
        else $error("byte_ready low with no record on the output");

    // Header records never report an open interface.
    assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && record_kind == ucdc_pkg::KIND_HEADER) |->
        (interface_number == 8'd0 && alternate_setting == 8'd0))
        else $error("header record carries interface fields");

    // Endpoint records only come from well-formed endpoint descriptors.
    assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && record_kind == ucdc_pkg::KIND_ENDPOINT) |->
        (descriptor_type == ucdc_pkg::DESC_ENDPOINT &&
         descriptor_length >= ucdc_pkg::ENDPOINT_MIN_LENGTH &&
         error_code == ucdc_pkg::ERR_NONE))
        else $error("endpoint record from a malformed descriptor");
`endif

endmodule
